FILE: hw/rtl/matrix_multiply_core_assert.svh
// ---------------------------------------------------------------------------
// matrix_multiply_core_assert.svh
// Assertion macros shared by the matrix multiply checkers.
// ---------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MMC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mm_pkg.sv
// ---------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the matrix multiply core.
// ---------------------------------------------------------------------------
`default_nettype none

package mm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;
  localparam int FUNC_W      = 2;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int RES_W       = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd4;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ERR
  } seq_state_t;

  // One step of the dot-product walk, travelling with the store read.
  typedef struct packed {
    logic             err;
    logic             first;
    logic             last_k;
    logic             last_el;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } token_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mm_store.sv
// ---------------------------------------------------------------------------
// mm_store
// Element stores for matrix A and matrix B, one write and one registered
// read per store and cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mm_store #(
  parameter int  MAX_DIM = mm_pkg::MAX_DIM_DEF,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      we_a,
  input  wire logic                      we_b,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [mm_pkg::ELEM_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [ADDR_W-1:0]         raddr_a,
  input  wire logic [ADDR_W-1:0]         raddr_b,
  output logic      [mm_pkg::ELEM_W-1:0] rd_a,
  output logic      [mm_pkg::ELEM_W-1:0] rd_b
);
  import mm_pkg::*;

  logic [ELEM_W-1:0] mem_a [DEPTH];
  logic [ELEM_W-1:0] mem_b [DEPTH];

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    if (re) begin
      rd_a <= mem_a[raddr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    if (re) begin
      rd_b <= mem_b[raddr_b];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mm_seq.sv
// ---------------------------------------------------------------------------
// mm_seq
// Request decode and row/column/inner-index sequencer; drives store
// writes for loads and store reads for a compute run.
// ---------------------------------------------------------------------------
`default_nettype none

module mm_seq #(
  parameter int  MAX_DIM = mm_pkg::MAX_DIM_DEF,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [mm_pkg::FUNC_W-1:0] func,
  input  wire logic [mm_pkg::IDX_W-1:0]  row_index,
  input  wire logic [mm_pkg::IDX_W-1:0]  col_index,
  input  wire logic [mm_pkg::ELEM_W-1:0] elem_value,
  input  wire logic [mm_pkg::DIM_W-1:0]  rows_a,
  input  wire logic [mm_pkg::DIM_W-1:0]  cols_a,
  input  wire logic [mm_pkg::DIM_W-1:0]  rows_b,
  input  wire logic [mm_pkg::DIM_W-1:0]  cols_b,
  input  wire logic                      stall,
  output logic                           we_a,
  output logic                           we_b,
  output logic      [ADDR_W-1:0]         waddr,
  output logic      [mm_pkg::ELEM_W-1:0] wdata,
  output logic                           re,
  output logic      [ADDR_W-1:0]         raddr_a,
  output logic      [ADDR_W-1:0]         raddr_b,
  output logic                           tok_valid,
  output mm_pkg::token_t                 tok
);
  import mm_pkg::*;

  seq_state_t state, state_next;

  logic [IDX_W-1:0] i_cnt, j_cnt, k_cnt;
  logic [IDX_W-1:0] i_last, j_last, k_last;
  logic [DIM_W-1:0] ra_eff, ca_eff, rb_eff, cb_eff;
  logic             accept, start, in_range, load_ok;
  logic             k_done, j_done, i_done;

  // Clamp a size register into 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign ra_eff = eff_dim(rows_a);
  assign ca_eff = eff_dim(cols_a);
  assign rb_eff = eff_dim(rows_b);
  assign cb_eff = eff_dim(cols_b);

  assign accept   = in_valid && in_ready;
  assign start    = accept && (func == FUNC_COMPUTE);
  assign in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
  assign load_ok  = accept && in_range;

  assign k_done = (k_cnt == k_last);
  assign j_done = (j_cnt == j_last);
  assign i_done = (i_cnt == i_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (ca_eff != rb_eff) ? ST_ERR : ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stall && k_done && j_done && i_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (!stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Walk k innermost, then column, then row.
  always_ff @(posedge clk) begin
    if (start) begin
      i_cnt  <= '0;
      j_cnt  <= '0;
      k_cnt  <= '0;
      i_last <= IDX_W'(ra_eff - 1'b1);
      j_last <= IDX_W'(cb_eff - 1'b1);
      k_last <= IDX_W'(ca_eff - 1'b1);
    end else if (state == ST_RUN && !stall) begin
      if (k_done) begin
        k_cnt <= '0;
        if (j_done) begin
          j_cnt <= '0;
          i_cnt <= i_cnt + 1'b1;
        end else begin
          j_cnt <= j_cnt + 1'b1;
        end
      end else begin
        k_cnt <= k_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    we_a      = load_ok && (func == FUNC_LOAD_A);
    we_b      = load_ok && (func == FUNC_LOAD_B);
    waddr     = ADDR_W'(int'(row_index) * MAX_DIM + int'(col_index));
    wdata     = elem_value;
    re        = !stall;
    raddr_a   = ADDR_W'(int'(i_cnt) * MAX_DIM + int'(k_cnt));
    raddr_b   = ADDR_W'(int'(k_cnt) * MAX_DIM + int'(j_cnt));
    tok_valid = 1'b0;
    tok       = '0;
    unique case (state)
      ST_IDLE: begin
        tok_valid = 1'b0;
      end
      ST_RUN: begin
        tok_valid   = 1'b1;
        tok.first   = (k_cnt == '0);
        tok.last_k  = k_done;
        tok.last_el = k_done && j_done && i_done;
        tok.row     = i_cnt;
        tok.col     = j_cnt;
      end
      ST_ERR: begin
        tok_valid   = 1'b1;
        tok.err     = 1'b1;
        tok.first   = 1'b1;
        tok.last_k  = 1'b1;
        tok.last_el = 1'b1;
      end
      default: tok_valid = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mm_mac.sv
// ---------------------------------------------------------------------------
// mm_mac
// Multiply-accumulate datapath: product stage, accumulator with 32-bit
// saturation, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mm_mac #(
  parameter int  MAX_DIM = mm_pkg::MAX_DIM_DEF,
  localparam int ACC_W   = mm_pkg::PROD_W + $clog2(MAX_DIM) + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      tok_valid,
  input  wire mm_pkg::token_t            tok,
  input  wire logic [mm_pkg::ELEM_W-1:0] rd_a,
  input  wire logic [mm_pkg::ELEM_W-1:0] rd_b,
  output logic                           stall,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [mm_pkg::IDX_W-1:0]  out_row,
  output logic      [mm_pkg::IDX_W-1:0]  out_col,
  output logic signed [mm_pkg::RES_W-1:0] out_value,
  output logic                           overflow,
  output logic                           size_error,
  output logic                           last_item
);
  import mm_pkg::*;

  logic                     v1, v2;
  token_t                   t1, t2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, prod_ext, sum;
  logic [ACC_W-RES_W:0]     sum_hi;
  logic                     sat, emit;
  logic [RES_W-1:0]         sat_val;

  assign stall = out_valid && !out_ready;

  // Token aligned with the registered store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (!stall) begin
      v1 <= tok_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      t1   <= tok;
      t2   <= t1;
      prod <= $signed(rd_a) * $signed(rd_b);
    end
  end

  assign prod_ext = ACC_W'(prod);
  assign sum      = t2.first ? prod_ext : acc + prod_ext;
  assign sum_hi   = sum[ACC_W-1:RES_W-1];
  assign sat      = !((&sum_hi) || (~|sum_hi));
  assign sat_val  = sum[ACC_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
  assign emit     = v2 && t2.last_k;

  always_ff @(posedge clk) begin
    if (v2 && !stall) begin
      acc <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !stall) begin
      last_item <= t2.last_el;
      if (t2.err) begin
        out_row    <= '0;
        out_col    <= '0;
        out_value  <= '0;
        overflow   <= 1'b0;
        size_error <= 1'b1;
      end else begin
        out_row    <= t2.row;
        out_col    <= t2.col;
        out_value  <= sat ? sat_val : sum[RES_W-1:0];
        overflow   <= sat;
        size_error <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/matrix_multiply_core.sv
// ---------------------------------------------------------------------------
// matrix_multiply_core
// Fixed-point matrix multiply over two element stores.
// ---------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_valid/cfg_ready writes rows_a, cols_a, rows_b or
//   cols_b (index 0..3); always ready. Write only while the core is idle.
//   Input requests (in_valid/in_ready): func 0/1 loads one Q8.8 element of
//   A/B at (row_index, col_index), one per cycle while idle; func 2 starts
//   a compute run; func 3 is taken and dropped.
//   Results (out_valid/out_ready): one Q16.16 element per result in
//   row-major order, last_item on the final one; a size mismatch gives a
//   single result with size_error and last_item set.
//   Flow: one store read per cycle unless the receiver stalls; a compute
//   run holds in_ready low while it walks the stores (on a mismatch,
//   while the error state waits). Loads may follow while the tail drains.
//   A stalled receiver freezes the read/MAC pipeline; the result register
//   holds until taken. Reset clears the pipeline and sets the size
//   registers to 4; store contents are undefined until loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_core #(
  parameter int  MAX_DIM = mm_pkg::MAX_DIM_DEF,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mm_pkg::DIM_W-1:0]     cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [mm_pkg::FUNC_W-1:0]    func,
  input  wire logic [mm_pkg::IDX_W-1:0]     row_index,
  input  wire logic [mm_pkg::IDX_W-1:0]     col_index,
  input  wire logic signed [mm_pkg::ELEM_W-1:0] elem_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [mm_pkg::IDX_W-1:0]     out_row,
  output logic      [mm_pkg::IDX_W-1:0]     out_col,
  output logic signed [mm_pkg::RES_W-1:0]   out_value,
  output logic                              overflow,
  output logic                              size_error,
  output logic                              last_item
);
  import mm_pkg::*;

  logic [DIM_W-1:0]  rows_a, cols_a, rows_b, cols_b;
  logic              stall, we_a, we_b, re, tok_valid;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [ELEM_W-1:0] wdata, rd_a, rd_b;
  token_t            tok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= DIM_RESET;
      cols_a <= DIM_RESET;
      rows_b <= DIM_RESET;
      cols_b <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS_A: rows_a <= cfg_data;
        CFG_COLS_A: cols_a <= cfg_data;
        CFG_ROWS_B: rows_b <= cfg_data;
        CFG_COLS_B: cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  mm_seq #(
    .MAX_DIM(MAX_DIM)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .row_index (row_index),
    .col_index (col_index),
    .elem_value(elem_value),
    .rows_a    (rows_a),
    .cols_a    (cols_a),
    .rows_b    (rows_b),
    .cols_b    (cols_b),
    .stall     (stall),
    .we_a      (we_a),
    .we_b      (we_b),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  mm_store #(
    .MAX_DIM(MAX_DIM)
  ) u_store (
    .clk    (clk),
    .we_a   (we_a),
    .we_b   (we_b),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

  mm_mac #(
    .MAX_DIM(MAX_DIM)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .stall     (stall),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .overflow  (overflow),
    .size_error(size_error),
    .last_item (last_item)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/mm_checker.sv
// ---------------------------------------------------------------------------
// mm_checker
// Port-level checks of the matrix multiply core, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "matrix_multiply_core_assert.svh"

module mm_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic [mm_pkg::FUNC_W-1:0]    func,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [mm_pkg::IDX_W-1:0]     out_row,
  input wire logic [mm_pkg::IDX_W-1:0]     out_col,
  input wire logic [mm_pkg::RES_W-1:0]     out_value,
  input wire logic                         overflow,
  input wire logic                         size_error,
  input wire logic                         last_item
);
  import mm_pkg::*;

  localparam int OUT_W = 2 * IDX_W + RES_W + 3;

  logic             out_stall, err_out, ovf_out, compute_take;
  logic             err_clean, sat_ok;
  logic [OUT_W-1:0] out_data;

  assign out_stall    = out_valid && !out_ready;
  assign err_out      = out_valid && size_error;
  assign ovf_out      = out_valid && overflow;
  assign compute_take = in_valid && in_ready && (func == FUNC_COMPUTE);
  assign out_data     = {out_row, out_col, out_value, overflow, size_error, last_item};
  assign err_clean    = last_item && !overflow && (out_value == '0) && (out_row == '0) &&
                        (out_col == '0);
  assign sat_ok       = (out_value == 32'h7FFF_FFFF) || (out_value == 32'h8000_0000);

  // hold the result while the receiver stalls
  `MMC_ASSERT_NXT(a_hold, clk, rst, out_stall, out_valid && $stable(out_data), "result changed")

  `MMC_ASSERT_IMP(a_err_result, clk, rst, err_out, err_clean, "size error result carries data")

  `MMC_ASSERT_IMP(a_sat_value, clk, rst, ovf_out, sat_ok, "overflow without saturated value")

  // a compute request drops in_ready in the cycle after it is taken
  `MMC_ASSERT_NXT(a_compute_busy, clk, rst, compute_take, !in_ready, "ready after compute")

endmodule

bind matrix_multiply_core mm_checker u_mm_checker (.*);

`default_nettype wire

FILE: tb/matrix_multiply_core_tb.sv
// ---------------------------------------------------------------------------
// matrix_multiply_core_tb
// Loads operand stores, runs compute requests under several size settings
// and checks every product element against an in-bench fixed-point model.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module matrix_multiply_core_tb;

  import mm_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake on any channel
  localparam int TAIL_CYCLES = 20;    // covers the drain of the read/MAC pipeline plus slack
  localparam int NUM_STEPS   = 30;
  localparam int DEPTH       = MAX_DIM_DEF * MAX_DIM_DEF;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [RES_W-1:0] value;
    logic             ovf;
    logic             err;
    logic             last;
  } product_t;

  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        code;   // function code or register index
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] value;  // element, or register data in the low bits
    logic              typed;
    product_t          res;
  } step_t;

  localparam product_t SIZE_ERR = {3'd0, 3'd0, 32'd0, 1'b0, 1'b1, 1'b1};

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0] row_index, col_index;
  logic signed [ELEM_W-1:0] elem_value;
  logic out_valid, out_ready;
  logic [IDX_W-1:0] out_row, out_col;
  logic signed [RES_W-1:0] out_value;
  logic overflow, size_error, last_item;

  // mirror of the block
  logic [DIM_W-1:0] dim_cfg [4];
  logic signed [ELEM_W-1:0] a_shadow [DEPTH];
  logic signed [ELEM_W-1:0] b_shadow [DEPTH];
  product_t product_q [$];

  // stimulus bookkeeping
  bit a_loaded [DEPTH];
  bit b_loaded [DEPTH];
  logic in_fire, cfg_fire;
  logic typed_valid;
  product_t typed_res;
  int req_sent;
  int in_idle_pct, out_stall_pct;
  int hold_req;
  int err_count;
  int quiet_cycles;
  logic moved;
  product_t got, want;
  step_t directed_steps [NUM_STEPS];
  int idle_plan [4] = '{0, 88, 0, 38};
  int stall_plan [4] = '{0, 0, 88, 38};

  matrix_multiply_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .row_index  (row_index),
    .col_index  (col_index),
    .elem_value (elem_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .overflow   (overflow),
    .size_error (size_error),
    .last_item  (last_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int used_dim(logic [DIM_W-1:0] code);
    if (code == 0) return 1;
    if (code > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(code);
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim_code();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return DIM_W'($urandom_range(1, 3));
    if (pick < 80) return DIM_W'($urandom_range(4, 6));
    if (pick < 88) return DIM_W'($urandom_range(7, 8));
    if (pick < 94) return '0;
    return DIM_W'($urandom_range(9, 15));
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return $urandom_range(1) ? 16'hffff : 16'h0100;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic product_t mk_prod(int r, int c, logic [RES_W-1:0] v, logic o, logic l);
    return {IDX_W'(r), IDX_W'(c), v, o, 1'b0, l};
  endfunction

  function automatic step_t cfg_step(logic [CFG_IDX_W-1:0] idx, int data);
    return {1'b1, idx, 3'd0, 3'd0, ELEM_W'(data), 1'b0, product_t'(0)};
  endfunction

  function automatic step_t req_step(logic [FUNC_W-1:0] f, int r, int c,
                                     logic [ELEM_W-1:0] v);
    return {1'b0, f, IDX_W'(r), IDX_W'(c), v, 1'b0, product_t'(0)};
  endfunction

  function automatic step_t compute_step(product_t res);
    return {1'b0, FUNC_COMPUTE, 3'd0, 3'd0, 16'd0, 1'b1, res};
  endfunction

  // Expected product elements for a compute request under the current sizes.
  task automatic queue_products();
    int ra, ca, rb, cb;
    longint acc;
    product_t p;
    ra = used_dim(dim_cfg[CFG_ROWS_A]);
    ca = used_dim(dim_cfg[CFG_COLS_A]);
    rb = used_dim(dim_cfg[CFG_ROWS_B]);
    cb = used_dim(dim_cfg[CFG_COLS_B]);
    if (ca != rb) begin
      product_q.push_back(SIZE_ERR);
      return;
    end
    for (int i = 0; i < ra; i++) begin
      for (int j = 0; j < cb; j++) begin
        acc = 0;
        for (int k = 0; k < ca; k++)
          acc += longint'(a_shadow[i * MAX_DIM_DEF + k]) *
                 longint'(b_shadow[k * MAX_DIM_DEF + j]);
        p = mk_prod(i, j, acc[RES_W-1:0], 1'b0, (i == ra - 1) && (j == cb - 1));
        if (acc > 64'sd2147483647) begin
          p.value = 32'h7fff_ffff;
          p.ovf = 1'b1;
        end else if (acc < -64'sd2147483648) begin
          p.value = 32'h8000_0000;
          p.ovf = 1'b1;
        end
        product_q.push_back(p);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      cfg_fire <= 1'b0;
      quiet_cycles = 0;
      for (int r = 0; r < 4; r++) dim_cfg[r] = DIM_RESET;
    end else begin
      in_fire <= in_valid && in_ready;
      cfg_fire <= cfg_valid && cfg_ready;
      moved = (in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready);
      if (cfg_valid && cfg_ready) dim_cfg[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        case (func)
          FUNC_LOAD_A: a_shadow[int'(row_index) * MAX_DIM_DEF + int'(col_index)] = elem_value;
          FUNC_LOAD_B: b_shadow[int'(row_index) * MAX_DIM_DEF + int'(col_index)] = elem_value;
          FUNC_COMPUTE: begin
            if (typed_valid) product_q.push_back(typed_res);
            else queue_products();
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_row, out_col, out_value, overflow, size_error, last_item};
        if (product_q.size() == 0) begin
          if (err_count < 40)
            $display("%0t: unexpected result row %0d col %0d value %h err %b", $time,
                     out_row, out_col, out_value, size_error);
          err_count++;
        end else begin
          want = product_q.pop_front();
          if (got !== want) begin
            if (err_count < 40)
              $display({"%0t: product mismatch, expected row %0d col %0d value %h ",
                        "ovf %b err %b last %b, actual row %0d col %0d value %h ",
                        "ovf %b err %b last %b"}, $time,
                       want.row, want.col, want.value, want.ovf, want.err, want.last,
                       got.row, got.col, got.value, got.ovf, got.err, got.last);
            err_count++;
          end
        end
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high after acceptance.
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] r,
                          input logic [IDX_W-1:0] c, input logic [ELEM_W-1:0] v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    func = f;
    row_index = r;
    col_index = c;
    elem_value = v;
    if (f == FUNC_LOAD_A) a_loaded[int'(r) * MAX_DIM_DEF + int'(c)] = 1'b1;
    if (f == FUNC_LOAD_B) b_loaded[int'(r) * MAX_DIM_DEF + int'(c)] = 1'b1;
    do @(negedge clk); while (!in_fire);
    req_sent++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(negedge clk); while (!cfg_fire);
  endtask

  // Drop both senders and wait until the block has gone quiet.
  task automatic settle();
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    while (product_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                          input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
    settle();
    write_cfg(CFG_ROWS_A, ra);
    write_cfg(CFG_COLS_A, ca);
    write_cfg(CFG_ROWS_B, rb);
    write_cfg(CFG_COLS_B, cb);
    cfg_valid = 1'b0;
  endtask

  // Load every operand entry the next compute reads that was never written.
  task automatic fill_operands();
    int ra, ca, rb, cb;
    ra = used_dim(dim_cfg[CFG_ROWS_A]);
    ca = used_dim(dim_cfg[CFG_COLS_A]);
    rb = used_dim(dim_cfg[CFG_ROWS_B]);
    cb = used_dim(dim_cfg[CFG_COLS_B]);
    if (ca != rb) return;
    for (int i = 0; i < ra; i++)
      for (int k = 0; k < ca; k++)
        if (!a_loaded[i * MAX_DIM_DEF + k])
          send_req(FUNC_LOAD_A, IDX_W'(i), IDX_W'(k), rand_elem());
    for (int k = 0; k < rb; k++)
      for (int j = 0; j < cb; j++)
        if (!b_loaded[k * MAX_DIM_DEF + j])
          send_req(FUNC_LOAD_B, IDX_W'(k), IDX_W'(j), rand_elem());
  endtask

  initial begin
    logic [DIM_W-1:0] ra, ca, rb, cb;
    int target, pick, da, dc, db, dd;
    bit was_req;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_LOAD_A;
    row_index = '0;
    col_index = '0;
    elem_value = '0;
    typed_valid = 1'b0;
    typed_res = '0;
    req_sent = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req = 0;
    err_count = 0;

    directed_steps = '{
      cfg_step(CFG_ROWS_A, 1), cfg_step(CFG_COLS_A, 1),
      cfg_step(CFG_ROWS_B, 1), cfg_step(CFG_COLS_B, 1),
      req_step(FUNC_LOAD_A, 0, 0, 16'h8000), req_step(FUNC_LOAD_B, 0, 0, 16'h8000),
      compute_step(mk_prod(0, 0, 32'h4000_0000, 1'b0, 1'b1)),
      req_step(FUNC_UNUSED, 7, 7, 16'hffff),
      req_step(FUNC_LOAD_A, 0, 0, 16'h7fff),
      compute_step(mk_prod(0, 0, 32'hc000_8000, 1'b0, 1'b1)),
      cfg_step(CFG_COLS_A, 2),
      compute_step(SIZE_ERR),
      cfg_step(CFG_ROWS_B, 2),
      req_step(FUNC_LOAD_A, 0, 0, 16'h8000), req_step(FUNC_LOAD_A, 0, 1, 16'h8000),
      req_step(FUNC_LOAD_B, 1, 0, 16'h8000),
      compute_step(mk_prod(0, 0, 32'h7fff_ffff, 1'b1, 1'b1)),
      cfg_step(CFG_COLS_A, 0),   // zero acts as one: mismatch against two rows
      compute_step(SIZE_ERR),
      cfg_step(CFG_ROWS_B, 0),
      compute_step(mk_prod(0, 0, 32'h4000_0000, 1'b0, 1'b1)),
      cfg_step(CFG_COLS_A, 3), cfg_step(CFG_ROWS_B, 3),
      req_step(FUNC_LOAD_A, 0, 2, 16'h8000), req_step(FUNC_LOAD_B, 0, 0, 16'h7fff),
      req_step(FUNC_LOAD_B, 1, 0, 16'h7fff), req_step(FUNC_LOAD_B, 2, 0, 16'h7fff),
      compute_step(mk_prod(0, 0, 32'h8000_0000, 1'b1, 1'b1)),
      cfg_step(CFG_COLS_A, 15),  // saturates to eight: mismatch against three rows
      compute_step(SIZE_ERR)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    was_req = 1'b0;
    foreach (directed_steps[s]) begin
      if (directed_steps[s].is_cfg) begin
        if (was_req) settle();
        write_cfg(directed_steps[s].code, directed_steps[s].value[DIM_W-1:0]);
        was_req = 1'b0;
      end else begin
        cfg_valid = 1'b0;
        typed_valid = directed_steps[s].typed;
        typed_res = directed_steps[s].res;
        send_req(directed_steps[s].code, directed_steps[s].row, directed_steps[s].col,
                 directed_steps[s].value);
        typed_valid = 1'b0;
        was_req = 1'b1;
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      in_idle_pct = idle_plan[phase];
      out_stall_pct = stall_plan[phase];
      target = req_sent + 60;
      while (req_sent < target) begin
        ra = rand_dim_code();
        ca = rand_dim_code();
        cb = rand_dim_code();
        if ($urandom_range(99) < 15) begin
          do rb = rand_dim_code(); while (used_dim(rb) == used_dim(ca));
        end else if (used_dim(ca) == 1) begin
          rb = $urandom_range(1) ? DIM_W'(0) : DIM_W'(1);
        end else if (used_dim(ca) == MAX_DIM_DEF) begin
          rb = DIM_W'($urandom_range(MAX_DIM_DEF, 15));
        end else begin
          rb = ca;
        end
        set_dims(ra, ca, rb, cb);
        da = used_dim(ra);
        dc = used_dim(ca);
        db = used_dim(rb);
        dd = used_dim(cb);
        repeat ($urandom_range(1, 3)) begin
          fill_operands();
          repeat ($urandom_range(0, 5)) begin
            pick = $urandom_range(99);
            if (pick < 10)
              send_req(FUNC_UNUSED, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
            else if (pick < 30)
              send_req(pick[0] ? FUNC_LOAD_B : FUNC_LOAD_A, IDX_W'($urandom),
                       IDX_W'($urandom), rand_elem());
            else if (pick[0])
              send_req(FUNC_LOAD_B, IDX_W'($urandom_range(db - 1)),
                       IDX_W'($urandom_range(dd - 1)), rand_elem());
            else
              send_req(FUNC_LOAD_A, IDX_W'($urandom_range(da - 1)),
                       IDX_W'($urandom_range(dc - 1)), rand_elem());
          end
          send_req(FUNC_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
        end
      end

      if (phase == 0) begin
        // Hold the receiver off while requests keep coming, so the core backs up.
        set_dims(4'd4, 4'd4, 4'd4, 4'd4);
        fill_operands();
        hold_req = 300;
        send_req(FUNC_COMPUTE, '0, '0, '0);
        repeat (4)
          send_req(FUNC_LOAD_A, IDX_W'($urandom_range(3)), IDX_W'($urandom_range(3)),
                   rand_elem());
        send_req(FUNC_COMPUTE, '0, '0, '0);
        send_req(FUNC_COMPUTE, '0, '0, '0);
      end
    end

    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
